// ===== hdl/thc_pkg.sv =====
`default_nettype none

package thc_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HYSTERESIS   = 1'b0,
        CFG_BLINK_PERIOD = 1'b1
    } cfg_index_t;

    localparam logic [6:0] HYSTERESIS_RESET   = 7'd5;
    localparam logic [7:0] BLINK_PERIOD_RESET = 8'd4;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_MODE      = 3'd1,
        OP_BTN_ONE   = 3'd2,
        OP_BTN_ZERO  = 3'd3,
        OP_DIGIT     = 3'd4,
        OP_BACKSPACE = 3'd5,
        OP_CONFIRM   = 3'd6
    } opcode_t;

    typedef enum logic [2:0] {
        ST_STABLE  = 3'd0,
        ST_HEATING = 3'd1,
        ST_COOLING = 3'd2,
        ST_MANUAL  = 3'd3,
        ST_ENTRY   = 3'd4
    } status_t;

    localparam logic [3:0] MAX_DECIMAL_DIGIT = 4'd9;
    localparam logic [7:0] BLINK_COUNT_MAX   = 8'd255;

    typedef struct packed {
        logic [2:0] opcode;
        logic [9:0] temp_sample;
        logic [9:0] trimpot_sample;
        logic [3:0] key_digit;
    } thc_item_t;

    typedef struct packed {
        logic       heater_drive;
        logic [9:0] fan_duty;
        logic       heater_led;
        logic       fan_led;
        logic       auto_mode;
        logic       entry_active;
        logic       keypad_setpoint_used;
        logic [9:0] setpoint;
        logic [1:0] entry_digits;
        logic [9:0] entry_value;
        logic [2:0] status;
    } thc_result_t;

    typedef struct packed {
        logic heater;
        logic fan;
    } thc_drive_t;

endpackage

`default_nettype wire

// ===== hdl/thc_event_if.sv =====
`default_nettype none

interface thc_event_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [9:0] temp_sample;
    logic [9:0] trimpot_sample;
    logic [3:0] key_digit;

    modport source (output valid, opcode, temp_sample, trimpot_sample, key_digit,
                    input ready);
    modport sink   (input valid, opcode, temp_sample, trimpot_sample, key_digit,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/thc_result_if.sv =====
`default_nettype none

interface thc_result_if;
    logic       valid;
    logic       ready;
    logic       heater_drive;
    logic [9:0] fan_duty;
    logic       heater_led;
    logic       fan_led;
    logic       auto_mode;
    logic       entry_active;
    logic       keypad_setpoint_used;
    logic [9:0] setpoint;
    logic [1:0] entry_digits;
    logic [9:0] entry_value;
    logic [2:0] status;

    modport source (output valid, heater_drive, fan_duty, heater_led, fan_led, auto_mode,
                    entry_active, keypad_setpoint_used, setpoint, entry_digits,
                    entry_value, status,
                    input ready);
    modport sink   (input valid, heater_drive, fan_duty, heater_led, fan_led, auto_mode,
                    entry_active, keypad_setpoint_used, setpoint, entry_digits,
                    entry_value, status,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/thc_hyst.sv =====
`default_nettype none

// Hysteresis decision. Temperature in degrees is temp*500/1023, so all
// comparisons are scaled by 1023 and the band is moved to the left side
// to keep everything unsigned.
module thc_hyst
    import thc_pkg::*;
#(
    parameter int SPW = 10
)
(
    input  wire logic [9:0]     temp_sample,
    input  wire logic [SPW-1:0] setpoint,
    input  wire logic [6:0]     hysteresis,
    input  wire thc_drive_t     drive_cur,
    output thc_drive_t          drive_next
);

    localparam int CW = SPW + 12;

    logic [CW-1:0] temp_scaled;
    logic [CW-1:0] sp_scaled;
    logic [CW-1:0] band_scaled;
    logic [CW-1:0] sp_band_scaled;
    logic [CW-1:0] temp_band;

    always_comb
    begin
        temp_scaled    = CW'(temp_sample) * CW'(500);
        sp_scaled      = CW'(setpoint) * CW'(1023);
        band_scaled    = CW'(hysteresis) * CW'(1023);
        sp_band_scaled = sp_scaled + band_scaled;
        temp_band      = temp_scaled + band_scaled;

        drive_next = drive_cur;
        // turn-on tests first, turn-off wins on a tie
        if (temp_band <= sp_scaled)
        begin
            drive_next.heater = 1'b1;
        end
        if (temp_scaled >= sp_scaled)
        begin
            drive_next.heater = 1'b0;
        end
        if (temp_scaled >= sp_band_scaled)
        begin
            drive_next.fan = 1'b1;
        end
        if (temp_scaled <= sp_scaled)
        begin
            drive_next.fan = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/thc_core.sv =====
`default_nettype none

module thc_core
    import thc_pkg::*;
#(
    parameter int MAX_DIGITS = 3,
    parameter int FULL_DUTY  = 1023
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire thc_item_t   item,
    input  wire logic [6:0]  hysteresis,
    input  wire logic [7:0]  blink_period,
    output thc_result_t      result
);

    localparam int TVW  = $clog2(10 ** MAX_DIGITS);
    localparam int CNTW = $clog2(MAX_DIGITS + 1);
    localparam int SPW  = (TVW > 10) ? TVW : 10;
    localparam logic [9:0] DUTY_ON = FULL_DUTY[9:0];

    logic            auto_reg,   auto_next;
    logic            entry_reg,  entry_next;
    logic            mheat_reg,  mheat_next;
    logic            mfan_reg,   mfan_next;
    thc_drive_t      adrive_reg, adrive_next;
    logic [7:0]      bcount_reg, bcount_next;
    logic            led_reg,    led_next;
    logic            keypad_reg, keypad_next;
    logic [TVW-1:0]  tv_reg,     tv_next;
    logic [CNTW-1:0] cnt_reg,    cnt_next;

    opcode_t          op;
    logic [17:0]      trim_prod;
    logic [SPW-1:0]   trim_sp;
    logic [SPW-1:0]   sp_cur;
    logic [SPW-1:0]   sp_new;
    logic [TVW+15:0]  tv_prod;
    logic [TVW-1:0]   tv_div10;
    logic [TVW+3:0]   tv_append;
    thc_drive_t       hyst_drive;
    logic             fan_on;
    logic [7:0]       bcount_inc;
    logic             heat_out;
    logic             fan_out;
    status_t          status_out;

    // divide by ten as multiply by reciprocal: exact over the ranges used
    assign trim_prod = 18'(item.trimpot_sample) * 18'd205;
    assign trim_sp   = SPW'(trim_prod >> 11);
    assign tv_prod   = (TVW+16)'(tv_reg) * (TVW+16)'(52429);
    assign tv_div10  = TVW'(tv_prod >> 19);
    assign tv_append = (TVW+4)'(tv_reg) * (TVW+4)'(10) + (TVW+4)'(item.key_digit);

    assign sp_cur = keypad_reg ? SPW'(tv_reg) : trim_sp;

    thc_hyst #(
        .SPW (SPW)
    ) u_hyst (
        .temp_sample (item.temp_sample),
        .setpoint    (sp_cur),
        .hysteresis  (hysteresis),
        .drive_cur   (adrive_reg),
        .drive_next  (hyst_drive)
    );

    always_comb
    begin
        op          = opcode_t'(item.opcode);
        auto_next   = auto_reg;
        entry_next  = entry_reg;
        mheat_next  = mheat_reg;
        mfan_next   = mfan_reg;
        adrive_next = adrive_reg;
        bcount_next = bcount_reg;
        led_next    = led_reg;
        keypad_next = keypad_reg;
        tv_next     = tv_reg;
        cnt_next    = cnt_reg;

        fan_on     = auto_reg ? hyst_drive.fan : mfan_reg;
        bcount_inc = (bcount_reg == BLINK_COUNT_MAX) ? bcount_reg : bcount_reg + 8'd1;

        if (entry_reg)
        begin
            if (op == OP_DIGIT && item.key_digit <= MAX_DECIMAL_DIGIT
                && cnt_reg < CNTW'(MAX_DIGITS))
            begin
                tv_next  = TVW'(tv_append);
                cnt_next = cnt_reg + CNTW'(1);
            end
            else if (op == OP_BACKSPACE && cnt_reg != '0)
            begin
                tv_next  = tv_div10;
                cnt_next = cnt_reg - CNTW'(1);
            end
            else if (op == OP_CONFIRM && cnt_reg != '0)
            begin
                keypad_next = 1'b1;
                entry_next  = 1'b0;
            end
        end
        else
        begin
            case (op)
                OP_MODE:
                begin
                    auto_next  = ~auto_reg;
                    mheat_next = 1'b0;
                    mfan_next  = 1'b0;
                    led_next   = 1'b0;
                end
                OP_BTN_ONE:
                begin
                    if (auto_reg)
                    begin
                        entry_next = 1'b1;
                        tv_next    = '0;
                        cnt_next   = '0;
                        led_next   = 1'b0;
                    end
                    else
                    begin
                        mheat_next = ~mheat_reg;
                    end
                end
                OP_BTN_ZERO:
                begin
                    if (auto_reg)
                    begin
                        keypad_next = 1'b0;
                    end
                    else
                    begin
                        mfan_next = ~mfan_reg;
                        if (mfan_reg)
                        begin
                            led_next = 1'b0;
                        end
                    end
                end
                OP_TICK:
                begin
                    if (auto_reg)
                    begin
                        adrive_next = hyst_drive;
                    end
                    if (fan_on)
                    begin
                        if (bcount_inc >= blink_period)
                        begin
                            led_next    = ~led_reg;
                            bcount_next = '0;
                        end
                        else
                        begin
                            bcount_next = bcount_inc;
                        end
                    end
                    else
                    begin
                        led_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_reg   <= 1'b0;
            entry_reg  <= 1'b0;
            mheat_reg  <= 1'b0;
            mfan_reg   <= 1'b0;
            adrive_reg <= '0;
            bcount_reg <= '0;
            led_reg    <= 1'b0;
            keypad_reg <= 1'b0;
            tv_reg     <= '0;
            cnt_reg    <= '0;
        end
        else if (en)
        begin
            auto_reg   <= auto_next;
            entry_reg  <= entry_next;
            mheat_reg  <= mheat_next;
            mfan_reg   <= mfan_next;
            adrive_reg <= adrive_next;
            bcount_reg <= bcount_next;
            led_reg    <= led_next;
            keypad_reg <= keypad_next;
            tv_reg     <= tv_next;
            cnt_reg    <= cnt_next;
        end
    end

    // result reflects the state after this transaction
    always_comb
    begin
        sp_new = keypad_next ? SPW'(tv_next) : trim_sp;
        if (entry_next)
        begin
            heat_out   = 1'b0;
            fan_out    = 1'b0;
            status_out = ST_ENTRY;
        end
        else if (!auto_next)
        begin
            heat_out   = mheat_next;
            fan_out    = mfan_next;
            status_out = ST_MANUAL;
        end
        else
        begin
            heat_out = adrive_next.heater;
            fan_out  = adrive_next.fan;
            if (adrive_next.heater)
            begin
                status_out = ST_HEATING;
            end
            else if (adrive_next.fan)
            begin
                status_out = ST_COOLING;
            end
            else
            begin
                status_out = ST_STABLE;
            end
        end

        result.heater_drive         = heat_out;
        result.fan_duty             = fan_out ? DUTY_ON : 10'd0;
        result.heater_led           = heat_out;
        result.fan_led              = entry_next ? 1'b0 : led_next;
        result.auto_mode            = auto_next;
        result.entry_active         = entry_next;
        result.keypad_setpoint_used = keypad_next;
        result.setpoint             = sp_new[9:0];
        result.entry_digits         = 2'(cnt_next);
        result.entry_value          = 10'(tv_next);
        result.status               = status_out;
    end

endmodule

`default_nettype wire

// ===== hdl/hysteresis_thermostat_controller_top.sv =====
// Flow: a transaction accepted at a clock edge is registered in the input register, then
// processed and its result registered in the output register and offered from then on;
// while the receiver holds off, the transaction waits and no new one is accepted.
// Throughput: one per cycle unless stalled, set by the single update of the control state.
// Reset (rst_n low, asynchronous): manual mode, all drives, LEDs and keypad entry cleared,
// hysteresis 5 and blink period 4; both pipeline registers empty.
`default_nettype none

module hysteresis_thermostat_controller_top
    import thc_pkg::*;
#(
    parameter int MAX_DIGITS = 3,
    parameter int FULL_DUTY  = 1023
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    thc_event_if.sink                   event_ch,
    thc_result_if.source                result_ch,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic        in_valid_reg;
    thc_item_t   item_reg;
    logic        out_valid_reg;
    thc_result_t result_reg;
    thc_result_t result_next;
    logic [6:0]  hyst_reg;
    logic [7:0]  period_reg;
    logic        advance;

    assign advance        = in_valid_reg && (!out_valid_reg || result_ch.ready);
    assign event_ch.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hyst_reg   <= HYSTERESIS_RESET;
            period_reg <= BLINK_PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_HYSTERESIS:   hyst_reg   <= cfg_data[6:0];
                CFG_BLINK_PERIOD: period_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (event_ch.ready)
            begin
                in_valid_reg <= event_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (event_ch.valid && event_ch.ready)
        begin
            item_reg.opcode         <= event_ch.opcode;
            item_reg.temp_sample    <= event_ch.temp_sample;
            item_reg.trimpot_sample <= event_ch.trimpot_sample;
            item_reg.key_digit      <= event_ch.key_digit;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    thc_core #(
        .MAX_DIGITS (MAX_DIGITS),
        .FULL_DUTY  (FULL_DUTY)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (advance),
        .item         (item_reg),
        .hysteresis   (hyst_reg),
        .blink_period (period_reg),
        .result       (result_next)
    );

    assign result_ch.valid                = out_valid_reg;
    assign result_ch.heater_drive         = result_reg.heater_drive;
    assign result_ch.fan_duty             = result_reg.fan_duty;
    assign result_ch.heater_led           = result_reg.heater_led;
    assign result_ch.fan_led              = result_reg.fan_led;
    assign result_ch.auto_mode            = result_reg.auto_mode;
    assign result_ch.entry_active         = result_reg.entry_active;
    assign result_ch.keypad_setpoint_used = result_reg.keypad_setpoint_used;
    assign result_ch.setpoint             = result_reg.setpoint;
    assign result_ch.entry_digits         = result_reg.entry_digits;
    assign result_ch.entry_value          = result_reg.entry_value;
    assign result_ch.status               = result_reg.status;

endmodule

`default_nettype wire

// ===== tb/sv/hysteresis_thermostat_controller_top_tb.sv =====
module hysteresis_thermostat_controller_top_tb;
    import thc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_DIGITS     = 3;
    localparam int FAN_FULL_DUTY  = 1023;
    localparam logic [9:0] FAN_DUTY_ON = FAN_FULL_DUTY[9:0];
    localparam logic [2:0] OP_UNUSED   = 3'd7;

    localparam int IDLE_PERCENT   = 21;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_EXTRA    = 4;
    localparam int END_SETTLE     = 10;
    localparam int REPORT_LIMIT   = 10;

    logic           clk;
    logic           rst_n;
    logic           cfg_we;
    cfg_index_t     cfg_index;
    logic [7:0]     cfg_data;

    thc_event_if    ev_ch ();
    thc_result_if   res_ch ();

    hysteresis_thermostat_controller_top #(
        .MAX_DIGITS (KEY_DIGITS),
        .FULL_DUTY  (FAN_FULL_DUTY)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .event_ch  (ev_ch),
        .result_ch (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // thermostat state as the predictor sees it
    logic [6:0]     cur_hyst         = HYSTERESIS_RESET;
    logic [7:0]     cur_blink_period = BLINK_PERIOD_RESET;
    logic           auto_on          = 1'b0;
    logic           entry_on         = 1'b0;
    logic           man_heater       = 1'b0;
    logic           man_fan          = 1'b0;
    logic           hyst_heater      = 1'b0;
    logic           hyst_fan         = 1'b0;
    logic [7:0]     blink_cnt        = '0;
    logic           fan_led_q        = 1'b0;
    logic           use_keypad_sp    = 1'b0;
    logic [9:0]     typed_val        = '0;
    logic [1:0]     typed_cnt        = '0;

    thc_result_t    expected_results[$];
    int             mismatch_count = 0;
    bit             steady_stream  = 1'b0;
    bit             rx_hold_req    = 1'b0;
    logic [9:0]     knob_sample    = 10'd500;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic thc_result_t thermostat_step(input thc_item_t it);
        thc_result_t r;
        int          t_scaled;
        int          sp_deg;
        int          band;
        logic        fan_on;
        logic        heat;
        logic        fan;

        sp_deg = use_keypad_sp ? int'(typed_val) : int'(it.trimpot_sample) / 10;
        if (entry_on)
        begin
            if (it.opcode == OP_DIGIT && it.key_digit <= MAX_DECIMAL_DIGIT
                && typed_cnt < KEY_DIGITS)
            begin
                typed_val = 10'(int'(typed_val) * 10 + int'(it.key_digit));
                typed_cnt = typed_cnt + 2'd1;
            end
            else if (it.opcode == OP_BACKSPACE && typed_cnt > 0)
            begin
                typed_cnt = typed_cnt - 2'd1;
                typed_val = 10'(int'(typed_val) / 10);
            end
            else if (it.opcode == OP_CONFIRM && typed_cnt > 0)
            begin
                use_keypad_sp = 1'b1;
                entry_on      = 1'b0;
            end
        end
        else if (it.opcode == OP_MODE)
        begin
            auto_on    = ~auto_on;
            man_heater = 1'b0;
            man_fan    = 1'b0;
            fan_led_q  = 1'b0;
        end
        else if (it.opcode == OP_BTN_ONE)
        begin
            if (auto_on)
            begin
                entry_on  = 1'b1;
                typed_val = '0;
                typed_cnt = '0;
                fan_led_q = 1'b0;
            end
            else
            begin
                man_heater = ~man_heater;
            end
        end
        else if (it.opcode == OP_BTN_ZERO)
        begin
            if (auto_on)
            begin
                use_keypad_sp = 1'b0;
            end
            else
            begin
                man_fan = ~man_fan;
                if (!man_fan)
                    fan_led_q = 1'b0;
            end
        end
        else if (it.opcode == OP_TICK)
        begin
            if (auto_on)
            begin
                // exact compare: sample*500 against degrees*1023, off wins a tie
                t_scaled = int'(it.temp_sample) * 500;
                band     = int'(cur_hyst);
                if (t_scaled <= (sp_deg - band) * 1023)
                    hyst_heater = 1'b1;
                if (t_scaled >= sp_deg * 1023)
                    hyst_heater = 1'b0;
                if (t_scaled >= (sp_deg + band) * 1023)
                    hyst_fan = 1'b1;
                if (t_scaled <= sp_deg * 1023)
                    hyst_fan = 1'b0;
                fan_on = hyst_fan;
            end
            else
            begin
                fan_on = man_fan;
            end
            if (fan_on)
            begin
                if (blink_cnt < BLINK_COUNT_MAX)
                    blink_cnt = blink_cnt + 8'd1;
                if (blink_cnt >= cur_blink_period)
                begin
                    fan_led_q = ~fan_led_q;
                    blink_cnt = '0;
                end
            end
            else
            begin
                fan_led_q = 1'b0;
            end
        end

        sp_deg = use_keypad_sp ? int'(typed_val) : int'(it.trimpot_sample) / 10;
        if (entry_on)
        begin
            heat     = 1'b0;
            fan      = 1'b0;
            r.status = ST_ENTRY;
        end
        else if (!auto_on)
        begin
            heat     = man_heater;
            fan      = man_fan;
            r.status = ST_MANUAL;
        end
        else
        begin
            heat     = hyst_heater;
            fan      = hyst_fan;
            r.status = heat ? ST_HEATING : (fan ? ST_COOLING : ST_STABLE);
        end
        r.heater_drive         = heat;
        r.fan_duty             = fan ? FAN_DUTY_ON : '0;
        r.heater_led           = heat;
        r.fan_led              = entry_on ? 1'b0 : fan_led_q;
        r.auto_mode            = auto_on;
        r.entry_active         = entry_on;
        r.keypad_setpoint_used = use_keypad_sp;
        r.setpoint             = sp_deg[9:0];
        r.entry_digits         = typed_cnt;
        r.entry_value          = typed_val;
        return r;
    endfunction

    function automatic thc_item_t make_event(input logic [2:0] op, input int temp,
                                             input int trim, input int digit);
        thc_item_t it;

        it.opcode         = op;
        it.temp_sample    = temp[9:0];
        it.trimpot_sample = trim[9:0];
        it.key_digit      = digit[3:0];
        return it;
    endfunction

    // mostly ticks (digits in entry) near the setpoint to cross the band often
    function automatic thc_item_t random_event();
        thc_item_t it;
        int        roll;
        int        sp_deg;
        int        centre;
        int        span;
        int        temp;

        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0)
            knob_sample = 10'($urandom_range(0, 1023));
        it.trimpot_sample = knob_sample;
        if ($urandom_range(0, 19) == 0)
            it.key_digit = 4'($urandom_range(10, 15));
        else
            it.key_digit = 4'($urandom_range(0, 9));

        if (entry_on)
        begin
            if (roll < 55)
                it.opcode = OP_DIGIT;
            else if (roll < 70)
                it.opcode = OP_BACKSPACE;
            else if (roll < 85)
                it.opcode = OP_CONFIRM;
            else if (roll < 92)
                it.opcode = OP_TICK;
            else if (roll < 96)
                it.opcode = OP_MODE;
            else
                it.opcode = roll[0] ? OP_BTN_ONE : OP_BTN_ZERO;
        end
        else
        begin
            if (roll < 62)
                it.opcode = OP_TICK;
            else if (roll < 68)
                it.opcode = OP_MODE;
            else if (roll < 80)
                it.opcode = OP_BTN_ONE;
            else if (roll < 90)
                it.opcode = OP_BTN_ZERO;
            else if (roll < 93)
                it.opcode = OP_DIGIT;
            else if (roll < 95)
                it.opcode = OP_BACKSPACE;
            else if (roll < 98)
                it.opcode = OP_CONFIRM;
            else
                it.opcode = OP_UNUSED;
        end

        if ($urandom_range(0, 99) < 70)
        begin
            sp_deg = use_keypad_sp ? int'(typed_val) : int'(knob_sample) / 10;
            centre = sp_deg * 1023 / 500;
            span   = (int'(cur_hyst) + 3) * 3;
            temp   = centre - span + int'($urandom_range(0, 2 * span));
            if (temp < 0)
                temp = 0;
            if (temp > 1023)
                temp = 1023;
            it.temp_sample = temp[9:0];
        end
        else
        begin
            it.temp_sample = 10'($urandom_range(0, 1023));
        end
        return it;
    endfunction

    function automatic string result_text(input thc_result_t r);
        return $sformatf({"heat=%0d duty=%0d hled=%0d fled=%0d auto=%0d entry=%0d ",
                          "kp=%0d sp=%0d digits=%0d value=%0d status=%0d"},
                         r.heater_drive, r.fan_duty, r.heater_led, r.fan_led,
                         r.auto_mode, r.entry_active, r.keypad_setpoint_used,
                         r.setpoint, r.entry_digits, r.entry_value, r.status);
    endfunction

    // offer one transaction, optionally after a random gap, and hold until taken
    task automatic send_event(input thc_item_t it);
        int gap;

        gap = 0;
        while (!steady_stream && $urandom_range(0, 99) < IDLE_PERCENT)
            gap++;
        if (gap > 0)
        begin
            ev_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ev_ch.valid          <= 1'b1;
        ev_ch.opcode         <= it.opcode;
        ev_ch.temp_sample    <= it.temp_sample;
        ev_ch.trimpot_sample <= it.trimpot_sample;
        ev_ch.key_digit      <= it.key_digit;
        @(posedge clk);
        while (!ev_ch.ready)
            @(posedge clk);
        expected_results.push_back(thermostat_step(it));
    endtask

    task automatic hold_until_drained();
        ev_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_EXTRA) @(posedge clk);
    endtask

    task automatic write_config(input cfg_index_t idx, input logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx == CFG_HYSTERESIS)
            cur_hyst = data[6:0];
        else
            cur_blink_period = data;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_thermostat_config(input int hyst, input int period);
        hold_until_drained();
        write_config(CFG_HYSTERESIS, hyst[7:0]);
        write_config(CFG_BLINK_PERIOD, period[7:0]);
    endtask

    task automatic run_random_events(input int count);
        repeat (count) send_event(random_event());
    endtask

    // manual buttons, fan LED blink at the reset period, ignored opcodes
    task automatic test_manual_buttons();
        send_event(make_event(OP_TICK, 0, 0, 0));
        send_event(make_event(OP_BTN_ONE, 0, 0, 0));
        send_event(make_event(OP_BTN_ZERO, 0, 0, 0));
        repeat (4) send_event(make_event(OP_TICK, 512, 300, 0));
        send_event(make_event(OP_DIGIT, 0, 0, 7));
        send_event(make_event(OP_CONFIRM, 0, 0, 0));
        send_event(make_event(OP_UNUSED, 0, 0, 0));
        send_event(make_event(OP_BTN_ZERO, 0, 0, 0));
        send_event(make_event(OP_TICK, 1023, 1023, 9));
    endtask

    // automatic mode with a zero band: exact ties, keypad entry edge cases
    task automatic test_auto_keypad();
        set_thermostat_config(0, BLINK_PERIOD_RESET);
        send_event(make_event(OP_MODE, 0, 0, 0));
        send_event(make_event(OP_TICK, 0, 5, 0));
        send_event(make_event(OP_TICK, 1023, 0, 0));
        send_event(make_event(OP_TICK, 0, 1023, 0));
        send_event(make_event(OP_BTN_ONE, 0, 0, 0));
        send_event(make_event(OP_TICK, 1023, 0, 0));
        send_event(make_event(OP_CONFIRM, 0, 0, 0));
        send_event(make_event(OP_BACKSPACE, 0, 0, 0));
        send_event(make_event(OP_DIGIT, 0, 0, 5));
        send_event(make_event(OP_DIGIT, 0, 0, 15));
        send_event(make_event(OP_DIGIT, 0, 0, 0));
        send_event(make_event(OP_DIGIT, 0, 0, 0));
        send_event(make_event(OP_DIGIT, 0, 0, 9));
        send_event(make_event(OP_BACKSPACE, 0, 0, 0));
        send_event(make_event(OP_DIGIT, 0, 0, 0));
        send_event(make_event(OP_MODE, 0, 0, 0));
        send_event(make_event(OP_CONFIRM, 0, 0, 0));
        send_event(make_event(OP_TICK, 1023, 200, 0));
        send_event(make_event(OP_BTN_ZERO, 0, 0, 0));
        send_event(make_event(OP_MODE, 0, 0, 0));
    endtask

    task automatic test_config_sweep();
        set_thermostat_config(0, 1);
        run_random_events(150);
        set_thermostat_config(100, 255);
        run_random_events(150);
        set_thermostat_config($urandom_range(0, 100), $urandom_range(1, 8));
        run_random_events(150);
        set_thermostat_config($urandom_range(0, 100), $urandom_range(1, 255));
        run_random_events(150);
    endtask

    task automatic test_steady_stream();
        set_thermostat_config(HYSTERESIS_RESET, BLINK_PERIOD_RESET);
        steady_stream = 1'b1;
        run_random_events(150);
        steady_stream = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_result_backpressure();
        rx_hold_req = 1'b1;
        run_random_events(40);
    endtask

    task automatic test_sender_pause();
        hold_until_drained();
        run_random_events(60);
        hold_until_drained();
        run_random_events(60);
    endtask

    initial
    begin : receiver_ready
        int hold;

        hold = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold        = RX_HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                res_ch.ready <= 1'b0;
            end
            else if (!steady_stream && $urandom_range(0, 99) < IDLE_PERCENT)
            begin
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin : result_checker
        thc_result_t got;
        thc_result_t want;

        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                got.heater_drive         = res_ch.heater_drive;
                got.fan_duty             = res_ch.fan_duty;
                got.heater_led           = res_ch.heater_led;
                got.fan_led              = res_ch.fan_led;
                got.auto_mode            = res_ch.auto_mode;
                got.entry_active         = res_ch.entry_active;
                got.keypad_setpoint_used = res_ch.keypad_setpoint_used;
                got.setpoint             = res_ch.setpoint;
                got.entry_digits         = res_ch.entry_digits;
                got.entry_value          = res_ch.entry_value;
                got.status               = res_ch.status;
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: unexpected result: %s", $time, result_text(got));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                        begin
                            $display("%0t: result mismatch", $time);
                            $display("  expected %s", result_text(want));
                            $display("  actual   %s", result_text(got));
                        end
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;

        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((ev_ch.valid && ev_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** hysteresis_thermostat_controller_top: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_HYSTERESIS;
        cfg_data             = '0;
        ev_ch.valid          = 1'b0;
        ev_ch.opcode         = OP_TICK;
        ev_ch.temp_sample    = '0;
        ev_ch.trimpot_sample = '0;
        ev_ch.key_digit      = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_manual_buttons();
        test_auto_keypad();
        test_config_sweep();
        test_steady_stream();
        test_result_backpressure();
        test_sender_pause();

        hold_until_drained();
        repeat (END_SETTLE) @(posedge clk);
        mismatch_count += expected_results.size();
        if (mismatch_count == 0)
            $display("** hysteresis_thermostat_controller_top: PASSED **");
        else
            $display("** hysteresis_thermostat_controller_top: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/thc_pkg.sv
hdl/thc_event_if.sv
hdl/thc_result_if.sv
hdl/thc_hyst.sv
hdl/thc_core.sv
hdl/hysteresis_thermostat_controller_top.sv
tb/sv/hysteresis_thermostat_controller_top_tb.sv
